### design/hpt_pkg.sv
// Package for the homogeneous point transform.
// Holds the item structs and the register reset values; used by all design files.
`timescale 1ns / 1ps
package hpt_pkg;

  localparam int NUM_CFG_REGS = 8;
  localparam int CFG_IDX_W    = 3;

  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [31:0] in_w;
  } point_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic               w_was_zero;
    logic               saturated;
  } result_t;

  localparam logic [63:0] CFG_RESET [NUM_CFG_REGS] = '{
    64'd65536, 64'd0, 64'd281474976710656, 64'd0,
    64'd0, 64'd65536, 64'd0, 64'd281474976710656
  };

endpackage

### design/homogeneous_point_transform.sv
// Homogeneous 4x4 point transform with perspective divide, top level.
// Depends on hpt_pkg for item structs and register reset values.
//
// Usage:
//   Input channel in_valid_i / in_stall_o carries one point (x, y, z, w, Q format
//   with FRAC_BITS fraction bits). Output channel out_valid_o / out_stall_i carries
//   the transformed point divided by the transformed w, plus zero-weight and
//   saturation flags. The matrix lives in eight 64-bit registers written through
//   cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i; write them only
//   while no item is in flight.
//   Throughput: one item per cycle while in_stall_o is low. The pipeline is 36
//   stages: multiply, sum, magnitude, divide setup and one restoring divide step
//   per quotient bit (32 steps), all three x/y/z dividers running side by side;
//   the divide steps set the depth.
//   A two-entry output buffer parts the pipeline from the receiver: while the
//   receiver stalls, the pipeline keeps taking items until the buffer is full,
//   then in_stall_o rises and the whole pipeline holds.
//   Reset clears all valid bits and loads the identity matrix.
`timescale 1ns / 1ps
module homogeneous_point_transform #(
  parameter int FRAC_BITS = 16,
  parameter int EPS_RECIP = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  hpt_pkg::point_t              in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output hpt_pkg::result_t             out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [hpt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]                  cfg_data_i
);
  import hpt_pkg::*;

  localparam int TW    = 66 - FRAC_BITS;
  localparam int AW    = TW - 1;
  localparam int RW    = AW + 33;
  localparam int NSTEP = 32;
  localparam int NST   = 4 + NSTEP;
  localparam longint unsigned POS_SC = 64'h7FFF_FFFF / EPS_RECIP;
  localparam longint unsigned NEG_SC = 64'h8000_0000 / EPS_RECIP;
  localparam logic [16:0] EPS_W = 17'(EPS_RECIP);
  localparam logic [31:0] ONE_W = 32'd1 << FRAC_BITS;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [31:0]   quo;
    logic          neg;
    logic          ovf;
    logic [31:0]   sres;
    logic          ssat;
  } lane_t;

  logic [63:0] cfg_q [NUM_CFG_REGS];

  logic [NST-1:0] v_q;
  logic           adv;

  logic signed [63:0] prod_q [4][4];
  logic signed [63:0] prod_d [4][4];
  logic signed [TW-1:0] sum_q [4];
  logic signed [TW-1:0] sum_d [4];
  logic [AW-1:0] a_q [3];
  logic [AW-1:0] a_d [3];
  logic [2:0]    neg_q, neg_d;
  logic [AW-1:0] b_q, b_d;
  logic          wz_q, wz_d;
  lane_t         lane_q [NSTEP+1][3];
  lane_t         lane_d [NSTEP+1][3];
  logic [AW-1:0] bp_q [NSTEP+1];
  logic          wzp_q [NSTEP+1];

  result_t res_d;
  result_t head_q, skid_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      cfg_q[cfg_index_i] <= cfg_data_i;
    end
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign adv        = !in_stall_o;

  // multiply
  always_comb begin
    point_t             p;
    logic signed [31:0] vin [4];
    p = in_data_i;
    vin[0] = p.in_x;
    vin[1] = p.in_y;
    vin[2] = p.in_z;
    vin[3] = p.in_w;
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 4; j++) begin
        prod_d[k][j] = vin[k] * $signed(cfg_q[2*k + (j >> 1)][32*(j & 1) +: 32]);
      end
    end
  end

  // sum of floored products
  always_comb begin
    logic signed [63:0] sh;
    for (int j = 0; j < 4; j++) begin
      sum_d[j] = '0;
      for (int k = 0; k < 4; k++) begin
        sh = prod_q[k][j] >>> FRAC_BITS;
        sum_d[j] = sum_d[j] + TW'(sh);
      end
    end
  end

  // signs and magnitudes
  always_comb begin
    logic signed [TW-1:0] mg;
    for (int j = 0; j < 3; j++) begin
      mg = sum_q[j][TW-1] ? -sum_q[j] : sum_q[j];
      a_d[j] = mg[AW-1:0];
      neg_d[j] = sum_q[j][TW-1] ^ sum_q[3][TW-1];
    end
    mg = sum_q[3][TW-1] ? -sum_q[3] : sum_q[3];
    b_d  = mg[AW-1:0];
    wz_d = (sum_q[3] == '0);
  end

  // divide setup and zero-weight scaling
  always_comb begin
    logic [48:0] sp;
    logic        sneg;
    for (int j = 0; j < 3; j++) begin
      sneg = neg_q[j];
      lane_d[0][j].rem  = RW'(a_q[j]) << FRAC_BITS;
      lane_d[0][j].quo  = '0;
      lane_d[0][j].neg  = neg_q[j];
      lane_d[0][j].ovf  = (RW'(a_q[j]) << FRAC_BITS) >= (RW'(b_q) << 32);
      // sign of a scaled result follows the component alone
      sneg = (neg_q[j] ^ (b_q != '0)) & (a_q[j] != '0);
      sp = {17'b0, a_q[j][31:0]} * {32'b0, EPS_W};
      if (wz_q) begin
        sneg = neg_q[j];
      end
      lane_d[0][j].ssat = sneg ? (a_q[j] > AW'(NEG_SC)) : (a_q[j] > AW'(POS_SC));
      if (lane_d[0][j].ssat) begin
        lane_d[0][j].sres = sneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        lane_d[0][j].sres = sneg ? -sp[31:0] : sp[31:0];
      end
    end
  end

  for (genvar n = 0; n < NSTEP; n++) begin : g_step
    always_comb begin
      logic [RW-1:0] bs;
      for (int j = 0; j < 3; j++) begin
        lane_d[n+1][j] = lane_q[n][j];
        bs = RW'(bp_q[n]) << (NSTEP - 1 - n);
        if (lane_q[n][j].rem >= bs) begin
          lane_d[n+1][j].rem = lane_q[n][j].rem - bs;
          lane_d[n+1][j].quo[NSTEP-1-n] = 1'b1;
        end
      end
    end
  end

  // final select and saturation
  always_comb begin
    logic [31:0] val [3];
    logic [2:0]  st;
    lane_t       ln;
    logic        qgt;
    for (int j = 0; j < 3; j++) begin
      ln  = lane_q[NSTEP][j];
      qgt = ln.neg ? (ln.quo[31] && (ln.quo[30:0] != '0)) : ln.quo[31];
      if (wzp_q[NSTEP]) begin
        val[j] = ln.sres;
        st[j]  = ln.ssat;
      end else if (ln.ovf || qgt) begin
        val[j] = ln.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        st[j]  = 1'b1;
      end else begin
        val[j] = ln.neg ? -ln.quo : ln.quo;
        st[j]  = 1'b0;
      end
    end
    res_d.out_x      = val[0];
    res_d.out_y      = val[1];
    res_d.out_z      = val[2];
    res_d.out_w      = wzp_q[NSTEP] ? 32'd0 : ONE_W;
    res_d.w_was_zero = wzp_q[NSTEP];
    res_d.saturated  = |st;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NST-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q   <= prod_d;
      sum_q    <= sum_d;
      a_q      <= a_d;
      neg_q    <= neg_d;
      b_q      <= b_d;
      wz_q     <= wz_d;
      bp_q[0]  <= b_q;
      wzp_q[0] <= wz_q;
      lane_q[0] <= lane_d[0];
      for (int n = 0; n < NSTEP; n++) begin
        lane_q[n+1] <= lane_d[n+1];
        bp_q[n+1]   <= bp_q[n];
        wzp_q[n+1]  <= wzp_q[n];
      end
    end
  end

  // output buffer
  assign push        = adv && v_q[NST-1];
  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_q == 2'd2) begin
      if (pop) begin
        head_q <= skid_q;
      end
    end else if (cnt_q == 2'd1) begin
      if (push && pop) begin
        head_q <= res_d;
      end else if (push) begin
        skid_q <= res_d;
      end
    end else if (push) begin
      head_q <= res_d;
    end
  end

endmodule

### design/hpt_checker.sv
// Port checker for the homogeneous point transform, bound to the top level.
// Depends on hpt_pkg for the item structs.
`timescale 1ns / 1ps
module hpt_checker #(
  parameter int FRAC_BITS = 16
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input hpt_pkg::result_t out_data_o
);
  import hpt_pkg::*;

  localparam logic [31:0] ONE_W = 32'd1 << FRAC_BITS;

  a_rst_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled item changed");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  a_w_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.w_was_zero && out_data_o.out_w == 32'd0) ||
                    (!out_data_o.w_was_zero && out_data_o.out_w == ONE_W))
    else $error("weight not normalized");

endmodule

bind homogeneous_point_transform hpt_checker #(.FRAC_BITS(FRAC_BITS)) u_hpt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);
